### src/segmented_memory_map_defines.svh
// assertion macros used by the rtl of the segmented memory map
`ifndef SEGMENTED_MEMORY_MAP_DEFINES_SVH
`define SEGMENTED_MEMORY_MAP_DEFINES_SVH

// same-cycle implication, checked on i_clk, off while in reset
`define SMM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("segmented memory map check failed");

// next-cycle implication, checked on i_clk, off while in reset
`define SMM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("segmented memory map check failed");

`endif

### src/smm_pkg.sv
package smm_pkg;

    localparam int MAX_SEG       = 3;
    localparam int DEF_SEGMENTS  = 3;
    localparam int DEF_SEG_BYTES = 4096;

    localparam int ADDR_W     = 32;
    localparam int DATA_W     = 32;
    localparam int SIZE_W     = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SEG0_BASE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEG0_SIZE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SEG1_BASE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SEG1_SIZE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SEG2_BASE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SEG2_SIZE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RO_MASK   = 3'd6;

    // actions
    localparam logic [1:0] ACT_READ  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_LOAD  = 2'd2;
    localparam logic [1:0] ACT_CLEAR = 2'd3;

    // access widths
    localparam logic [1:0] WC_BYTE = 2'd0;
    localparam logic [1:0] WC_HALF = 2'd1;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_SEG   = 2'd1;
    localparam logic [1:0] ST_PAST_END = 2'd2;
    localparam logic [1:0] ST_RO_WRITE = 2'd3;

    typedef struct packed {
        logic [1:0]        action;
        logic [ADDR_W-1:0] address;
        logic [1:0]        width_code;
        logic [DATA_W-1:0] write_data;
    } t_in_item;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic [1:0]        status;
    } t_out_item;

    // decoded access
    typedef struct packed {
        logic [1:0]        seg;
        logic [1:0]        status;
        logic [ADDR_W-1:0] offset;
        logic [2:0]        nbytes;
        logic              rd;
        logic              wr;
    } t_dec;

endpackage

### src/smm_ram.sv
module smm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                                     i_clk,
    input  logic                                     i_en,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                         i_wdata,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/smm_decode.sv
module smm_decode #(
    parameter int SEGMENTS  = smm_pkg::DEF_SEGMENTS,
    parameter int SEG_BYTES = smm_pkg::DEF_SEG_BYTES
) (
    input  smm_pkg::t_in_item                                      i_item,
    input  logic [smm_pkg::MAX_SEG-1:0][smm_pkg::ADDR_W-1:0]       i_seg_base,
    input  logic [smm_pkg::MAX_SEG-1:0][smm_pkg::SIZE_W-1:0]       i_seg_size,
    input  logic [smm_pkg::MAX_SEG-1:0]                            i_ro_mask,
    output smm_pkg::t_dec                                          o_dec
);

    import smm_pkg::*;

    logic [ADDR_W:0]   lo   [MAX_SEG];
    logic [ADDR_W:0]   eff  [MAX_SEG];
    logic [MAX_SEG-1:0] hit;

    // range test per segment on 33 bits
    always_comb begin
        for (int i = 0; i < MAX_SEG; i++) begin
            lo[i]  = {1'b0, i_seg_base[i]};
            eff[i] = (33'(i_seg_size[i]) > 33'(SEG_BYTES)) ? 33'(SEG_BYTES)
                                                             : 33'(i_seg_size[i]);
            hit[i] = (i < SEGMENTS) &&
                     ({1'b0, i_item.address} >= lo[i]) &&
                     ({1'b0, i_item.address} < (lo[i] + eff[i]));
        end
    end

    always_comb begin
        logic              found;
        logic [1:0]        seg;
        logic [ADDR_W:0]   seg_eff;
        logic [ADDR_W-1:0] seg_base;
        logic [2:0]        nb;
        logic [ADDR_W-1:0] off;

        found    = 1'b0;
        seg      = 2'd0;
        seg_eff  = eff[0];
        seg_base = i_seg_base[0];
        // lowest index wins
        for (int i = MAX_SEG - 1; i >= 0; i--) begin
            if (hit[i]) begin
                found    = 1'b1;
                seg      = 2'(i);
                seg_eff  = eff[i];
                seg_base = i_seg_base[i];
            end
        end

        case (i_item.width_code)
            WC_BYTE: nb = 3'd1;
            WC_HALF: nb = 3'd2;
            default: nb = 3'd4;
        endcase

        off = i_item.address - seg_base;

        o_dec.seg    = seg;
        o_dec.offset = off;
        o_dec.nbytes = nb;
        o_dec.rd     = 1'b0;
        o_dec.wr     = 1'b0;
        o_dec.status = ST_OK;

        if (i_item.action != ACT_CLEAR) begin
            if (!found) begin
                o_dec.status = ST_NO_SEG;
            end else if (i_item.action == ACT_WRITE && i_ro_mask[seg]) begin
                o_dec.status = ST_RO_WRITE;
            end else if (({1'b0, off} + 33'(nb)) > seg_eff) begin
                o_dec.status = ST_PAST_END;
            end else if (i_item.action == ACT_READ) begin
                o_dec.rd = 1'b1;
            end else begin
                o_dec.wr = 1'b1;
            end
        end
    end

endmodule

### src/segmented_memory_map.sv
// an item is taken into the input stage, issues its memory access as it moves on to the
// memory stage, and its result is then registered in the output stage that drives o_out_valid
// throughput: one item per cycle unless a clear or result back-pressure stalls it; each
// segment store is four byte lanes, so an unaligned access touches every byte in a single memory access
// a clear sweeps one row a cycle, (SEG_BYTES+3)/4 rows; input blocked meanwhile, then its result goes out
// reset (synchronous, i_rst_n low) clears config, valid flags and sweep state; stores kept
`include "segmented_memory_map_defines.svh"

module segmented_memory_map #(
    parameter int SEGMENTS  = smm_pkg::DEF_SEGMENTS,
    parameter int SEG_BYTES = smm_pkg::DEF_SEG_BYTES
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration writes
    input  logic                             i_cfg_we,
    input  logic [smm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [smm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // access channel
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  smm_pkg::t_in_item                i_in_item,
    // result channel
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output smm_pkg::t_out_item               o_out_item
);

    import smm_pkg::*;

    // each store is split into four byte lanes, lane = byte offset mod 4
    localparam int ROWS = (SEG_BYTES + 3) / 4;
    localparam int RAW  = (ROWS > 1) ? $clog2(ROWS) : 1;

    typedef enum logic [2:0] {
        CLR_IDLE  = 3'b001,
        CLR_SWEEP = 3'b010,
        CLR_DONE  = 3'b100
    } t_clr_state;

    // configuration registers
    logic [MAX_SEG-1:0][ADDR_W-1:0] r_seg_base;
    logic [MAX_SEG-1:0][SIZE_W-1:0] r_seg_size;
    logic [MAX_SEG-1:0]             r_ro_mask;

    // input stage
    logic     r_a_valid;
    t_in_item r_a_item;

    // memory stage: read data from the lanes is valid while r_b_valid
    logic       r_b_valid;
    logic [1:0] r_b_status;
    logic       r_b_rd;
    logic [1:0] r_b_seg;
    logic [1:0] r_b_lane0;
    logic [2:0] r_b_nbytes;

    // output register
    logic      r_o_valid;
    t_out_item r_o_item;

    // clear sweep
    t_clr_state       r_clr_state, n_clr_state;
    logic [RAW-1:0]   r_clr_row, n_clr_row;

    t_dec       dec;
    logic [1:0] lane0;
    logic       o_free, b_go, b_free, a_go, a_issue, in_acc;
    logic [SEGMENTS-1:0][3:0][7:0] ram_q;
    logic [DATA_W-1:0] rd_word;

    // config writes; the user must issue them only while the block is idle, the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_base <= '0;
            r_seg_size <= '0;
            r_ro_mask  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SEG0_BASE: r_seg_base[0] <= i_cfg_data[ADDR_W-1:0];
                REG_SEG0_SIZE: r_seg_size[0] <= i_cfg_data[SIZE_W-1:0];
                REG_SEG1_BASE: r_seg_base[1] <= i_cfg_data[ADDR_W-1:0];
                REG_SEG1_SIZE: r_seg_size[1] <= i_cfg_data[SIZE_W-1:0];
                REG_SEG2_BASE: r_seg_base[2] <= i_cfg_data[ADDR_W-1:0];
                REG_SEG2_SIZE: r_seg_size[2] <= i_cfg_data[SIZE_W-1:0];
                REG_RO_MASK:   r_ro_mask     <= i_cfg_data[MAX_SEG-1:0];
                default: ;
            endcase
        end
    end

    // segment lookup and fault check on the held item
    smm_decode #(
        .SEGMENTS  (SEGMENTS),
        .SEG_BYTES (SEG_BYTES)
    ) u_decode (
        .i_item     (r_a_item),
        .i_seg_base (r_seg_base),
        .i_seg_size (r_seg_size),
        .i_ro_mask  (r_ro_mask),
        .o_dec      (dec)
    );

    assign lane0 = dec.offset[1:0];

    // stage handshake: each stage moves when the one after it can take the item
    assign o_free  = !r_o_valid || i_out_ready;
    assign b_go    = r_b_valid && o_free;
    assign b_free  = !r_b_valid || b_go;
    // a clear item leaves the input stage only once its sweep is done
    assign a_go    = r_a_valid && b_free &&
                     ((r_a_item.action != ACT_CLEAR) || (r_clr_state == CLR_DONE));
    assign a_issue = a_go && (r_a_item.action != ACT_CLEAR);

    assign o_in_ready = !r_a_valid || a_go;
    assign in_acc     = i_in_valid && o_in_ready;

    // lane memories: segment s, lane b holds bytes b, b+4, b+8, ... of the store
    for (genvar s = 0; s < SEGMENTS; s++) begin : g_seg
        logic sweep_wr;
        assign sweep_wr = (r_clr_state == CLR_SWEEP) && !r_ro_mask[s];

        for (genvar b = 0; b < 4; b++) begin : g_lane
            logic [1:0]        idx;
            logic              used;
            logic [1:0]        pos;
            logic [ADDR_W-1:0] row;
            logic              acc;
            logic              ram_en;
            logic              ram_we;
            logic [RAW-1:0]    ram_addr;
            logic [7:0]        ram_wd;

            // byte number within the access that falls in this lane
            assign idx  = 2'(b) - lane0;
            assign used = ({1'b0, idx} < dec.nbytes);
            // big-endian: byte 0 is the most significant
            assign pos  = 2'(dec.nbytes - 3'd1 - {1'b0, idx});
            // lanes below the start lane wrap into the next row
            assign row  = (dec.offset >> 2) + ((2'(b) < lane0) ? 32'd1 : 32'd0);
            assign acc  = a_issue && (dec.rd || dec.wr) && (dec.seg == 2'(s)) && used;

            assign ram_en   = sweep_wr || acc;
            assign ram_we   = sweep_wr || (acc && dec.wr);
            assign ram_addr = sweep_wr ? r_clr_row : row[RAW-1:0];
            assign ram_wd   = sweep_wr ? 8'd0 : 8'(r_a_item.write_data >> {pos, 3'b000});

            smm_ram #(
                .WIDTH (8),
                .DEPTH (ROWS)
            ) u_ram (
                .i_clk   (i_clk),
                .i_en    (ram_en),
                .i_we    (ram_we),
                .i_addr  (ram_addr),
                .i_wdata (ram_wd),
                .o_rdata (ram_q[s][b])
            );
        end
    end

    // gather the read bytes back into a big-endian word
    always_comb begin
        logic [3:0][7:0] sel;
        logic [1:0]      idx;
        logic [1:0]      pos;

        sel     = '0;
        rd_word = '0;
        for (int s = 0; s < SEGMENTS; s++) begin
            if (r_b_seg == 2'(s)) begin
                sel = ram_q[s];
            end
        end
        for (int b = 0; b < 4; b++) begin
            idx = 2'(b) - r_b_lane0;
            pos = 2'(r_b_nbytes - 3'd1 - {1'b0, idx});
            if ({1'b0, idx} < r_b_nbytes) begin
                rd_word[{pos, 3'b000} +: 8] = sel[b];
            end
        end
        if (!r_b_rd) begin
            rd_word = '0;
        end
    end

    // clear sweep: one row of every writable store per cycle
    always_comb begin
        n_clr_state = r_clr_state;
        n_clr_row   = r_clr_row;
        case (r_clr_state)
            CLR_IDLE: begin
                if (r_a_valid && (r_a_item.action == ACT_CLEAR)) begin
                    n_clr_state = CLR_SWEEP;
                    n_clr_row   = '0;
                end
            end
            CLR_SWEEP: begin
                if (r_clr_row == RAW'(ROWS - 1)) begin
                    n_clr_state = CLR_DONE;
                end else begin
                    n_clr_row = r_clr_row + RAW'(1);
                end
            end
            CLR_DONE: begin
                if (a_go) begin
                    n_clr_state = CLR_IDLE;
                end
            end
            default: n_clr_state = CLR_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_state <= CLR_IDLE;
            r_clr_row   <= '0;
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            r_clr_state <= n_clr_state;
            r_clr_row   <= n_clr_row;

            if (in_acc) begin
                r_a_valid <= 1'b1;
            end else if (a_go) begin
                r_a_valid <= 1'b0;
            end

            if (a_go) begin
                r_b_valid <= 1'b1;
            end else if (b_go) begin
                r_b_valid <= 1'b0;
            end

            if (b_go) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_item <= i_in_item;
        end
        if (a_go) begin
            r_b_status <= dec.status;
            r_b_rd     <= dec.rd;
            r_b_seg    <= dec.seg;
            r_b_lane0  <= lane0;
            r_b_nbytes <= dec.nbytes;
        end
        if (b_go) begin
            r_o_item.read_data <= rd_word;
            r_o_item.status    <= r_b_status;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_item  = r_o_item;

    // no new item is taken while a clear is sweeping the stores
    `SMM_ASSERT_NOW(a_no_accept_in_sweep, r_clr_state == CLR_SWEEP, !o_in_ready)
    // a clear item only moves on after its sweep has finished
    `SMM_ASSERT_NOW(a_clear_after_sweep, a_go && (r_a_item.action == ACT_CLEAR),
        r_clr_state == CLR_DONE)
    // faults and non-reads never carry data; this check covers the faults
    `SMM_ASSERT_NOW(a_fault_no_data, o_out_valid && (o_out_item.status != ST_OK),
        o_out_item.read_data == '0)
    // the sweep always ends in the done state, never straight back to idle
    `SMM_ASSERT_NEXT(a_sweep_exit, (r_clr_state == CLR_SWEEP) && (r_clr_row == RAW'(ROWS - 1)),
        r_clr_state == CLR_DONE)

endmodule

### verif/testbench.sv
module testbench;

    import smm_pkg::*;

    // shape of the block under test
    localparam int SEG_COUNT   = DEF_SEGMENTS;
    localparam int STORE_BYTES = DEF_SEG_BYTES;

    // width codes the package leaves unnamed
    localparam logic [1:0] WC_WORD     = 2'd2;
    localparam logic [1:0] WC_WORD_ALT = 2'd3;

    // a clear item sweeps one store row per cycle; the pause before a map change
    // and the drain at the end both cover a full sweep plus the pipeline
    localparam int SWEEP_CYCLES  = (DEF_SEG_BYTES + 3) / 4;
    localparam int SETTLE_CYCLES = SWEEP_CYCLES + 16;
    localparam int RANDOM_PER_MAP = 190;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    t_in_item              i_in_item  = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_item             o_out_item;

    segmented_memory_map dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // shadow of the address map and the three segment stores
    // ---------------------------------------------------------------
    logic [ADDR_W-1:0] seg_base [SEG_COUNT];
    logic [SIZE_W-1:0] seg_size [SEG_COUNT];
    logic [2:0]        seg_ro;
    logic [7:0]        seg_mem  [SEG_COUNT][STORE_BYTES];

    // items waiting to be presented, and results owed by the block
    t_in_item  pending_accesses [$];
    t_out_item due_results      [$];
    // recent write targets, so reads often land on data just stored
    logic [ADDR_W-1:0] recent_addr [$];

    int n_sent;
    int n_taken;
    int n_checked;
    int n_clears;
    int n_maps;
    int mismatch_count;
    int tx_idle_pct;
    int rx_idle_pct;

    // a size above the store depth counts as the full store
    function automatic int unsigned seg_span(int s);
        return (seg_size[s] > STORE_BYTES) ? STORE_BYTES : seg_size[s];
    endfunction

    // lowest enabled segment holding the address; bounds kept on 64 bits so the
    // top of a segment near the end of the address space never wraps to zero
    function automatic int find_seg(logic [ADDR_W-1:0] addr);
        longint lo;
        for (int s = 0; s < SEG_COUNT; s++) begin
            lo = longint'(seg_base[s]);
            if (longint'(addr) >= lo && longint'(addr) < lo + seg_span(s))
                return s;
        end
        return -1;
    endfunction

    // expected result of one accepted access, updating the shadow stores
    function automatic t_out_item predict_access(t_in_item it);
        t_out_item         res;
        int                s;
        int                nb;
        logic [ADDR_W-1:0] off;
        res = '0;
        case (it.width_code)
            WC_BYTE: nb = 1;
            WC_HALF: nb = 2;
            default: nb = 4;    // the fourth code is a word as well
        endcase
        if (it.action == ACT_CLEAR) begin
            // only writable segments are zeroed; address, width and data ignored
            for (int k = 0; k < SEG_COUNT; k++)
                if (!seg_ro[k])
                    for (int b = 0; b < STORE_BYTES; b++)
                        seg_mem[k][b] = 8'h00;
        end else begin
            s = find_seg(it.address);
            if (s < 0) begin
                res.status = ST_NO_SEG;
            end else begin
                off = it.address - seg_base[s];
                // read-only wins over running past the end
                if (it.action == ACT_WRITE && seg_ro[s]) begin
                    res.status = ST_RO_WRITE;
                end else if (longint'(off) + nb > seg_span(s)) begin
                    res.status = ST_PAST_END;
                end else if (it.action == ACT_READ) begin
                    // big-endian: lowest address is the top byte
                    for (int i = 0; i < nb; i++)
                        res.read_data = (res.read_data << 8) | seg_mem[s][off + i];
                end else begin
                    for (int i = 0; i < nb; i++)
                        seg_mem[s][off + i] = it.write_data[8 * (nb - 1 - i) +: 8];
                end
            end
        end
        return res;
    endfunction

    // ---------------------------------------------------------------
    // access channel driver: one item per handshake, random gaps
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                // item taken at this edge: owe its result from now on
                due_results.push_back(predict_access(i_in_item));
                n_taken++;
            end
            // a presented item holds until taken
            if (!i_in_valid || o_in_ready) begin
                if (pending_accesses.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    i_in_item  <= pending_accesses.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // result channel monitor: random stalls, field-by-field compare
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_checked++;
            if (due_results.size() == 0) begin
                $display("%0t: result with nothing owed: read_data %h status %0d",
                         $time, o_out_item.read_data, o_out_item.status);
                mismatch_count++;
            end else begin
                want = due_results.pop_front();
                if (o_out_item.read_data !== want.read_data) begin
                    $display("%0t: read_data expected %h got %h",
                             $time, want.read_data, o_out_item.read_data);
                    mismatch_count++;
                end
                if (o_out_item.status !== want.status) begin
                    $display("%0t: status expected %0d got %0d",
                             $time, want.status, o_out_item.status);
                    mismatch_count++;
                end
            end
        end
        i_out_ready <= i_rst_n ? ($urandom_range(99) >= rx_idle_pct) : 1'b0;
    end

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------
    function automatic void push_access(logic [1:0] act, logic [ADDR_W-1:0] addr,
                                        logic [1:0] wc, logic [DATA_W-1:0] data);
        t_in_item it;
        it.action     = act;
        it.address    = addr;
        it.width_code = wc;
        it.write_data = data;
        pending_accesses.push_back(it);
        n_sent++;
        if (act == ACT_CLEAR)
            n_clears++;
        if (act == ACT_WRITE || act == ACT_LOAD) begin
            recent_addr.push_back(addr);
            if (recent_addr.size() > 8)
                void'(recent_addr.pop_front());
        end
    endfunction

    // addresses aimed at the current map: inside, across the end, just below
    // the base, back on recent writes, and a few anywhere
    function automatic logic [ADDR_W-1:0] pick_address();
        int          s;
        int unsigned span;
        int unsigned r;
        s    = $urandom_range(SEG_COUNT - 1);
        span = seg_span(s);
        r    = $urandom_range(99);
        if (r < 8)
            return $urandom;
        if (r < 16)
            return seg_base[s] - $urandom_range(4, 1);
        if (span == 0 || r < 28)
            return seg_base[s] + span - $urandom_range(3);
        if (recent_addr.size() != 0 && r < 60)
            return recent_addr[$urandom_range(recent_addr.size() - 1)];
        return seg_base[s] + $urandom_range(span - 1);
    endfunction

    function automatic void push_random_access();
        int unsigned r;
        logic [1:0]  act;
        r = $urandom_range(999);
        if (r < 15)
            act = ACT_CLEAR;
        else if (r < 470)
            act = ACT_READ;
        else if (r < 820)
            act = ACT_WRITE;
        else
            act = ACT_LOAD;
        push_access(act, pick_address(), 2'($urandom_range(3)), $urandom);
    endfunction

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            REG_SEG0_BASE: seg_base[0] = val;
            REG_SEG0_SIZE: seg_size[0] = val[SIZE_W-1:0];
            REG_SEG1_BASE: seg_base[1] = val;
            REG_SEG1_SIZE: seg_size[1] = val[SIZE_W-1:0];
            REG_SEG2_BASE: seg_base[2] = val;
            REG_SEG2_SIZE: seg_size[2] = val[SIZE_W-1:0];
            REG_RO_MASK:   seg_ro      = val[2:0];
            default: ;
        endcase
    endtask

    // full address map, written only while the block is idle
    task automatic load_map(input logic [31:0] b0, input int s0, input logic [31:0] b1,
                            input int s1, input logic [31:0] b2, input int s2,
                            input logic [2:0] ro);
        set_reg(REG_SEG0_BASE, b0);
        set_reg(REG_SEG0_SIZE, s0);
        set_reg(REG_SEG1_BASE, b1);
        set_reg(REG_SEG1_SIZE, s1);
        set_reg(REG_SEG2_BASE, b2);
        set_reg(REG_SEG2_SIZE, s2);
        set_reg(REG_RO_MASK, CFG_DATA_W'(ro));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        n_maps++;
    endtask

    // wait until every item is taken and answered, then cover a clear sweep
    task automatic settle();
        while (n_taken != n_sent || due_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_burst();
        repeat (RANDOM_PER_MAP) push_random_access();
    endtask

    initial begin
        logic [31:0] rb;
        n_sent = 0; n_taken = 0; n_checked = 0; n_clears = 0; n_maps = 0;
        mismatch_count = 0;
        seg_ro = '0;
        for (int s = 0; s < SEG_COUNT; s++) begin
            seg_base[s] = '0;
            seg_size[s] = '0;
        end
        // sender idles 37 of 100, receiver 77
        tx_idle_pct = 37;
        rx_idle_pct = 77;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // map with two overlapping segments and one flush with the top of the
        // address space; first everything writable so a clear defines all stores
        load_map(32'h0000_0000, 4096, 32'h0000_0800, 4096, 32'hFFFF_F000, 4096, 3'b000);
        push_access(ACT_CLEAR, 32'h0, WC_BYTE, 32'h0);
        settle();
        load_map(32'h0000_0000, 4096, 32'h0000_0800, 4096, 32'hFFFF_F000, 4096, 3'b100);

        // directed: widths, big-endian order, fault order, load, clear
        push_access(ACT_WRITE, 32'h0000_0000, WC_WORD, 32'hA1B2_C3D4);
        push_access(ACT_READ,  32'h0000_0000, WC_WORD, 32'h0);
        push_access(ACT_READ,  32'h0000_0001, WC_BYTE, 32'h0);
        push_access(ACT_READ,  32'h0000_0002, WC_HALF, 32'h0);
        push_access(ACT_WRITE, 32'h0000_0010, WC_WORD_ALT, 32'h0F1E_2D3C);
        push_access(ACT_READ,  32'h0000_0010, WC_WORD_ALT, 32'hFFFF_FFFF);
        push_access(ACT_WRITE, 32'h0000_0030, WC_BYTE, 32'hFFFF_FF7E);
        push_access(ACT_READ,  32'h0000_0030, WC_HALF, 32'h0);
        // seg0 wins the overlap; word at its last bytes runs past the end
        push_access(ACT_WRITE, 32'h0000_0FFE, WC_WORD, 32'h1234_5678);
        push_access(ACT_READ,  32'h0000_0FFF, WC_BYTE, 32'h0);
        push_access(ACT_WRITE, 32'h0000_1800, WC_HALF, 32'hFFFF_FFFF);
        push_access(ACT_WRITE, 32'h0000_17FE, WC_HALF, 32'h0000_BEEF);
        push_access(ACT_READ,  32'h0000_17FE, WC_HALF, 32'h0);
        push_access(ACT_WRITE, 32'h0000_17FF, WC_HALF, 32'h0000_5555);
        // read-only segment: read-only fault beats past-end, load ignores the flag
        push_access(ACT_WRITE, 32'hFFFF_FFFE, WC_WORD, 32'hDEAD_BEEF);
        push_access(ACT_WRITE, 32'hFFFF_F000, WC_BYTE, 32'h0000_00AA);
        push_access(ACT_LOAD,  32'hFFFF_FFFC, WC_WORD, 32'h1122_3344);
        push_access(ACT_LOAD,  32'hFFFF_FFFE, WC_WORD, 32'h9988_7766);
        push_access(ACT_READ,  32'hFFFF_FFFC, WC_WORD, 32'h0);
        // clear zeroes writable stores only
        push_access(ACT_WRITE, 32'h0000_0020, WC_BYTE, 32'h0000_005A);
        push_access(ACT_CLEAR, 32'hFFFF_FFFF, WC_WORD_ALT, 32'hFFFF_FFFF);
        push_access(ACT_READ,  32'h0000_0020, WC_BYTE, 32'h0);
        push_access(ACT_READ,  32'hFFFF_FFFC, WC_WORD, 32'h0);
        push_access(ACT_READ,  32'h8000_0000, WC_WORD, 32'h0);
        push_access(ACT_READ,  32'hFFFF_FFFF, WC_BYTE, 32'h0);
        random_burst();

        // small seg0 shadowing the start of seg1, seg1 read-only, seg2 off
        settle();
        load_map(32'h1000_0000, 64, 32'h1000_0020, 4096, 32'h0000_0000, 0, 3'b010);
        random_burst();

        // now the sender idles more than the receiver
        settle();
        tx_idle_pct = 77;
        rx_idle_pct = 37;
        // oversized size registers, a one-byte segment
        load_map(32'h4000_0000, 8191, 32'h2000_0000, 5000, 32'h3000_0000, 1, 3'b101);
        random_burst();

        // all read-only; a single-byte window at the very top must not wrap onto
        // the low segment at address zero
        settle();
        load_map(32'hFFFF_FFFF, 4096, 32'h0000_0000, 0, 32'h0000_0000, 16, 3'b111);
        random_burst();

        // no idling on either side from here on
        settle();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rb = $urandom;
        load_map(rb, $urandom_range(8191), rb + $urandom_range(8192), $urandom_range(8191),
                 $urandom, $urandom_range(4096), 3'($urandom_range(7)));
        random_burst();

        // two tiny adjacent segments packed below a full-size one
        settle();
        load_map(32'h0000_0000, 4, 32'h0000_0004, 4, 32'h0000_0008, 4096, 3'b000);
        random_burst();

        settle();
        $display("run: %0d accesses over %0d address maps, %0d clears, %0d results checked",
                 n_sent, n_maps, n_clears, n_checked);
        $display("run: idle mixes 37/77, 77/37 and none; %0d mismatches", mismatch_count);
        if (mismatch_count == 0 && due_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // hang guard, far above the slowest legal run
    initial begin
        #4000000;
        $display("tb: failure");
        $finish;
    end

endmodule
